// File: rtl/qlsf_pkg.sv
// Shared types, constants and width helpers for the quadratic least-squares fit.
// Used by qlsf_front, qlsf_queue, qlsf_back and quadratic_least_squares_fit.
`default_nettype none

package qlsf_pkg;

  localparam int MAX_POINTS_DEF   = 256;
  localparam int SAMPLE_WIDTH_DEF = 12;
  localparam int FRAC_BITS_DEF    = 16;
  localparam int MIN_POINTS       = 3;
  localparam int COEF_W           = 48;
  localparam int QUEUE_DEPTH      = 2;
  localparam int PROG_LEN         = 30;
  localparam int DET_STEP         = 8;
  localparam int STEP_W           = 5;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FEW      = 2'd1,
    ST_SINGULAR = 2'd2,
    ST_TOO_MANY = 2'd3
  } fit_status_t;

  // Operand sources of the shared multiply-accumulate unit.
  typedef enum logic [3:0] {
    OP_S00, OP_S10, OP_S20, OP_S30, OP_S40, OP_S01, OP_S11, OP_S21,
    OP_M1, OP_M2, OP_M3, OP_T
  } opnd_t;

  typedef enum logic [1:0] {
    BASE_ZERO, BASE_ACC, BASE_DB, BASE_DC
  } base_t;

  typedef enum logic [3:0] {
    DST_NONE, DST_M1, DST_M2, DST_M3, DST_DET, DST_DA, DST_DB, DST_DC, DST_T
  } dst_t;

  typedef struct packed {
    opnd_t a;
    opnd_t b;
    base_t base;
    logic  sub;
    dst_t  dst;
  } uop_t;

  typedef enum logic [3:0] {
    BK_IDLE, BK_SETUP, BK_MUL, BK_CHECK, BK_DIV_SETUP, BK_DIV, BK_ROUND, BK_SAT,
    BK_DONE
  } bk_state_t;

  // Width of the point counter: it must hold MAX_POINTS + 1.
  function automatic int count_w(input int max_points);
    return $clog2(max_points + 2);
  endfunction

  // Width of a running sum over terms of the given total degree.
  function automatic int sum_w(input int sw, input int cw, input int deg);
    return (sw - 1) * deg + cw + 1;
  endfunction

  // Working width of the solver; holds every Cramer term times 2^frac.
  function automatic int work_w(input int sw, input int cw, input int frac);
    int w;
    w = 7 * (sw - 1) + 3 * cw + frac + 8;
    if (w < COEF_W + 1) begin
      w = COEF_W + 1;
    end
    return w;
  endfunction

  function automatic uop_t mk(input opnd_t a, input opnd_t b, input base_t base,
                              input logic sub, input dst_t dst);
    uop_t u;
    u.a = a;
    u.b = b;
    u.base = base;
    u.sub = sub;
    u.dst = dst;
    return u;
  endfunction

  // Solve program: minors, determinant, then the three Cramer numerators.
  function automatic uop_t prog_step(input logic [STEP_W-1:0] idx);
    uop_t u;
    case (idx)
      5'd0:  u = mk(OP_S20, OP_S00, BASE_ZERO, 1'b0, DST_NONE);
      5'd1:  u = mk(OP_S10, OP_S10, BASE_ACC,  1'b1, DST_M1);
      5'd2:  u = mk(OP_S30, OP_S00, BASE_ZERO, 1'b0, DST_NONE);
      5'd3:  u = mk(OP_S10, OP_S20, BASE_ACC,  1'b1, DST_M2);
      5'd4:  u = mk(OP_S30, OP_S10, BASE_ZERO, 1'b0, DST_NONE);
      5'd5:  u = mk(OP_S20, OP_S20, BASE_ACC,  1'b1, DST_M3);
      5'd6:  u = mk(OP_S40, OP_M1,  BASE_ZERO, 1'b0, DST_NONE);
      5'd7:  u = mk(OP_S30, OP_M2,  BASE_ACC,  1'b1, DST_NONE);
      5'd8:  u = mk(OP_S20, OP_M3,  BASE_ACC,  1'b0, DST_DET);
      5'd9:  u = mk(OP_S21, OP_M1,  BASE_ZERO, 1'b0, DST_NONE);
      5'd10: u = mk(OP_S11, OP_M2,  BASE_ACC,  1'b1, DST_NONE);
      5'd11: u = mk(OP_S01, OP_M3,  BASE_ACC,  1'b0, DST_DA);
      5'd12: u = mk(OP_S11, OP_S00, BASE_ZERO, 1'b0, DST_NONE);
      5'd13: u = mk(OP_S01, OP_S10, BASE_ACC,  1'b1, DST_T);
      5'd14: u = mk(OP_S40, OP_T,   BASE_ZERO, 1'b0, DST_DB);
      5'd15: u = mk(OP_S21, OP_S00, BASE_ZERO, 1'b0, DST_NONE);
      5'd16: u = mk(OP_S01, OP_S20, BASE_ACC,  1'b1, DST_T);
      5'd17: u = mk(OP_S30, OP_T,   BASE_DB,   1'b1, DST_DB);
      5'd18: u = mk(OP_S21, OP_S10, BASE_ZERO, 1'b0, DST_NONE);
      5'd19: u = mk(OP_S11, OP_S20, BASE_ACC,  1'b1, DST_T);
      5'd20: u = mk(OP_S20, OP_T,   BASE_DB,   1'b0, DST_DB);
      5'd21: u = mk(OP_S20, OP_S01, BASE_ZERO, 1'b0, DST_NONE);
      5'd22: u = mk(OP_S10, OP_S11, BASE_ACC,  1'b1, DST_T);
      5'd23: u = mk(OP_S40, OP_T,   BASE_ZERO, 1'b0, DST_DC);
      5'd24: u = mk(OP_S30, OP_S01, BASE_ZERO, 1'b0, DST_NONE);
      5'd25: u = mk(OP_S10, OP_S21, BASE_ACC,  1'b1, DST_T);
      5'd26: u = mk(OP_S30, OP_T,   BASE_DC,   1'b1, DST_DC);
      5'd27: u = mk(OP_S30, OP_S11, BASE_ZERO, 1'b0, DST_NONE);
      5'd28: u = mk(OP_S20, OP_S21, BASE_ACC,  1'b1, DST_T);
      5'd29: u = mk(OP_S20, OP_T,   BASE_DC,   1'b0, DST_DC);
      default: u = mk(OP_S00, OP_S00, BASE_ZERO, 1'b0, DST_NONE);
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

// File: rtl/qlsf_front.sv
// Front end: takes sample words, forms the powers and keeps the running sums.
// On the last point it hands a snapshot of the sums to the queue. Uses qlsf_pkg.
`default_nettype none

module qlsf_front #(
  parameter int MAX_POINTS   = qlsf_pkg::MAX_POINTS_DEF,
  parameter int SAMPLE_WIDTH = qlsf_pkg::SAMPLE_WIDTH_DEF,
  localparam int SW  = SAMPLE_WIDTH,
  localparam int CW  = qlsf_pkg::count_w(MAX_POINTS),
  localparam int S1W = qlsf_pkg::sum_w(SW, CW, 1),
  localparam int S2W = qlsf_pkg::sum_w(SW, CW, 2),
  localparam int S3W = qlsf_pkg::sum_w(SW, CW, 3),
  localparam int S4W = qlsf_pkg::sum_w(SW, CW, 4),
  localparam int PW  = 2 + CW + 2 * S1W + 2 * S2W + 2 * S3W + S4W
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic signed [SW-1:0] in_x_value,
  input  wire logic signed [SW-1:0] in_y_value,
  input  wire logic                 in_last_point,
  input  wire logic                 in_push,
  output logic                      in_full,
  output logic                      q_push,
  input  wire logic                 q_full,
  output logic [PW-1:0]             q_data
);

  logic                  v1_r, v2_r;
  logic signed [SW-1:0]  x1_r, y1_r, x2_r, y2_r;
  logic                  last1_r, last2_r;
  logic signed [2*SW-1:0] sq_r, xy_r;

  logic [CW-1:0]          cnt_r, cnt_nxt, cnt_inc;
  logic signed [S1W-1:0]  sx_r, sy_r, sx_nxt, sy_nxt;
  logic signed [S2W-1:0]  sxx_r, sxy_r, sxx_nxt, sxy_nxt;
  logic signed [S3W-1:0]  sx3_r, sxxy_r, sx3_nxt, sxxy_nxt;
  logic signed [S4W-1:0]  sx4_r, sx4_nxt;

  logic signed [3*SW-1:0] cube, sqy;
  logic signed [4*SW-1:0] quad;
  logic accept, adv2, mv1, take, add_en;
  qlsf_pkg::fit_status_t cls;

  assign accept  = in_push & ~v1_r;
  assign in_full = v1_r;
  assign adv2    = v2_r & ~(last2_r & q_full);
  assign mv1     = v1_r & (~v2_r | adv2);

  assign cube = sq_r * x2_r;
  assign quad = sq_r * sq_r;
  assign sqy  = sq_r * y2_r;

  always_comb begin
    take    = (cnt_r <= CW'(MAX_POINTS));
    cnt_inc = cnt_r + 1'b1;
    add_en  = take && (cnt_inc <= CW'(MAX_POINTS));
    cnt_nxt = take ? cnt_inc : cnt_r;
    sx_nxt   = add_en ? sx_r + S1W'(x2_r) : sx_r;
    sxx_nxt  = add_en ? sxx_r + S2W'(sq_r) : sxx_r;
    sx3_nxt  = add_en ? sx3_r + S3W'(cube) : sx3_r;
    sx4_nxt  = add_en ? sx4_r + S4W'(quad) : sx4_r;
    sy_nxt   = add_en ? sy_r + S1W'(y2_r) : sy_r;
    sxy_nxt  = add_en ? sxy_r + S2W'(xy_r) : sxy_r;
    sxxy_nxt = add_en ? sxxy_r + S3W'(sqy) : sxxy_r;
    if (cnt_nxt > CW'(MAX_POINTS)) begin
      cls = qlsf_pkg::ST_TOO_MANY;
    end else if (cnt_nxt < CW'(qlsf_pkg::MIN_POINTS)) begin
      cls = qlsf_pkg::ST_FEW;
    end else begin
      cls = qlsf_pkg::ST_OK;
    end
  end

  assign q_push = adv2 & last2_r;
  assign q_data = {cls, cnt_nxt, sx_nxt, sxx_nxt, sx3_nxt, sx4_nxt,
                   sy_nxt, sxy_nxt, sxxy_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      cnt_r  <= '0;
      sx_r   <= '0;
      sxx_r  <= '0;
      sx3_r  <= '0;
      sx4_r  <= '0;
      sy_r   <= '0;
      sxy_r  <= '0;
      sxxy_r <= '0;
    end else begin
      if (accept) begin
        v1_r <= 1'b1;
      end else if (mv1) begin
        v1_r <= 1'b0;
      end
      if (mv1) begin
        v2_r <= 1'b1;
      end else if (adv2) begin
        v2_r <= 1'b0;
      end
      if (adv2) begin
        if (last2_r) begin
          cnt_r  <= '0;
          sx_r   <= '0;
          sxx_r  <= '0;
          sx3_r  <= '0;
          sx4_r  <= '0;
          sy_r   <= '0;
          sxy_r  <= '0;
          sxxy_r <= '0;
        end else begin
          cnt_r  <= cnt_nxt;
          sx_r   <= sx_nxt;
          sxx_r  <= sxx_nxt;
          sx3_r  <= sx3_nxt;
          sx4_r  <= sx4_nxt;
          sy_r   <= sy_nxt;
          sxy_r  <= sxy_nxt;
          sxxy_r <= sxxy_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x1_r    <= in_x_value;
      y1_r    <= in_y_value;
      last1_r <= in_last_point;
    end
    if (mv1) begin
      x2_r    <= x1_r;
      y2_r    <= y1_r;
      last2_r <= last1_r;
      sq_r    <= x1_r * x1_r;
      xy_r    <= x1_r * y1_r;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_POINTS + 1))
    else $error("point counter beyond its limit");

endmodule

`default_nettype wire

// File: rtl/qlsf_queue.sv
// Short queue of sum snapshots between the front end and the solver.
// Depth from qlsf_pkg::QUEUE_DEPTH; the word width is a parameter.
`default_nettype none

module qlsf_queue #(
  parameter int W = 8,
  localparam int DEPTH = qlsf_pkg::QUEUE_DEPTH,
  localparam int PTR_W = $clog2(DEPTH),
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] wr_data,
  output logic              full,
  input  wire logic         pop,
  output logic [W-1:0]      rd_data,
  output logic              empty
);

  logic [W-1:0]     mem_r [DEPTH];
  logic [PTR_W-1:0] wp_r, rp_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (wp_r == PTR_W'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= (rp_r == PTR_W'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

// File: rtl/qlsf_back.sv
// Solver: runs the Cramer program on one shift-add multiply unit, then three
// restoring divisions with rounding and saturation. Uses qlsf_pkg.
`default_nettype none

module qlsf_back #(
  parameter int MAX_POINTS   = qlsf_pkg::MAX_POINTS_DEF,
  parameter int SAMPLE_WIDTH = qlsf_pkg::SAMPLE_WIDTH_DEF,
  parameter int FRAC_BITS    = qlsf_pkg::FRAC_BITS_DEF,
  localparam int SW  = SAMPLE_WIDTH,
  localparam int CW  = qlsf_pkg::count_w(MAX_POINTS),
  localparam int S1W = qlsf_pkg::sum_w(SW, CW, 1),
  localparam int S2W = qlsf_pkg::sum_w(SW, CW, 2),
  localparam int S3W = qlsf_pkg::sum_w(SW, CW, 3),
  localparam int S4W = qlsf_pkg::sum_w(SW, CW, 4),
  localparam int PW  = 2 + CW + 2 * S1W + 2 * S2W + 2 * S3W + S4W,
  localparam int WW  = qlsf_pkg::work_w(SW, CW, FRAC_BITS),
  localparam int CFW = qlsf_pkg::COEF_W
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  q_empty,
  input  wire logic [PW-1:0]         q_data,
  output logic                       q_pop,
  input  wire logic                  out_pop,
  output logic                       out_empty,
  output logic signed [CFW-1:0]      out_coef_a,
  output logic signed [CFW-1:0]      out_coef_b,
  output logic signed [CFW-1:0]      out_coef_c,
  output logic [1:0]                 out_fit_status
);

  localparam int O_S11 = S3W;
  localparam int O_S01 = O_S11 + S2W;
  localparam int O_S40 = O_S01 + S1W;
  localparam int O_S30 = O_S40 + S4W;
  localparam int O_S20 = O_S30 + S3W;
  localparam int O_S10 = O_S20 + S2W;
  localparam int O_CNT = O_S10 + S1W;
  localparam int O_CLS = O_CNT + CW;
  localparam int DCW   = $clog2(WW);

  qlsf_pkg::bk_state_t state_r, state_nxt;

  logic signed [WW-1:0] s00_r, s10_r, s20_r, s30_r, s40_r, s01_r, s11_r, s21_r;
  logic signed [WW-1:0] m1_r, m2_r, m3_r, t_r, det_r, da_r, db_r, dc_r;
  logic signed [WW-1:0] acc_r, mc_r;
  logic [WW-1:0]        mp_r;
  logic                 neg_r;
  logic [qlsf_pkg::STEP_W-1:0] step_r;

  logic [WW-1:0]  dn_r, dd_r, r_r, q_r;
  logic [DCW-1:0] dcnt_r;
  logic [1:0]     kidx_r;
  logic           dneg_r;

  logic signed [CFW-1:0] coef_a_r, coef_b_r, coef_c_r;
  qlsf_pkg::fit_status_t st_r, ld_cls;
  logic res_v_r;

  qlsf_pkg::uop_t uop;
  logic signed [WW-1:0] opa, opb, base_val, num_sel;
  logic [WW-1:0]        opb_abs, num_abs, det_abs, rs;
  logic                 start, mul_done, div_last, ge, rnd_up, big;
  logic signed [CFW-1:0] sat_val;
  logic [CFW-1:0]       mag;

  assign uop    = qlsf_pkg::prog_step(step_r);
  assign ld_cls = qlsf_pkg::fit_status_t'(q_data[O_CLS +: 2]);

  always_comb begin
    case (uop.a)
      qlsf_pkg::OP_S00: opa = s00_r;
      qlsf_pkg::OP_S10: opa = s10_r;
      qlsf_pkg::OP_S20: opa = s20_r;
      qlsf_pkg::OP_S30: opa = s30_r;
      qlsf_pkg::OP_S40: opa = s40_r;
      qlsf_pkg::OP_S01: opa = s01_r;
      qlsf_pkg::OP_S11: opa = s11_r;
      qlsf_pkg::OP_S21: opa = s21_r;
      qlsf_pkg::OP_M1:  opa = m1_r;
      qlsf_pkg::OP_M2:  opa = m2_r;
      qlsf_pkg::OP_M3:  opa = m3_r;
      default:          opa = t_r;
    endcase
    case (uop.b)
      qlsf_pkg::OP_S00: opb = s00_r;
      qlsf_pkg::OP_S10: opb = s10_r;
      qlsf_pkg::OP_S20: opb = s20_r;
      qlsf_pkg::OP_S30: opb = s30_r;
      qlsf_pkg::OP_S40: opb = s40_r;
      qlsf_pkg::OP_S01: opb = s01_r;
      qlsf_pkg::OP_S11: opb = s11_r;
      qlsf_pkg::OP_S21: opb = s21_r;
      qlsf_pkg::OP_M1:  opb = m1_r;
      qlsf_pkg::OP_M2:  opb = m2_r;
      qlsf_pkg::OP_M3:  opb = m3_r;
      default:          opb = t_r;
    endcase
    case (uop.base)
      qlsf_pkg::BASE_ZERO: base_val = '0;
      qlsf_pkg::BASE_ACC:  base_val = acc_r;
      qlsf_pkg::BASE_DB:   base_val = db_r;
      default:             base_val = dc_r;
    endcase
    case (kidx_r)
      2'd0:    num_sel = da_r;
      2'd1:    num_sel = db_r;
      default: num_sel = dc_r;
    endcase
  end

  always_comb begin
    opb_abs  = opb[WW-1] ? WW'(-opb) : opb;
    num_abs  = num_sel[WW-1] ? WW'(-num_sel) : num_sel;
    det_abs  = det_r[WW-1] ? WW'(-det_r) : det_r;
    mul_done = (mp_r == '0);
    div_last = (dcnt_r == DCW'(WW - 1));
    rs       = {r_r[WW-2:0], dn_r[WW-1]};
    ge       = (rs >= dd_r);
    rnd_up   = ({r_r, 1'b0} >= {1'b0, dd_r});
    big      = |q_r[WW-1:CFW-1];
    mag      = q_r[CFW-1:0];
    if (big) begin
      sat_val = dneg_r ? {1'b1, {(CFW-1){1'b0}}} : {1'b0, {(CFW-1){1'b1}}};
    end else begin
      sat_val = dneg_r ? CFW'(-mag) : mag;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      qlsf_pkg::BK_IDLE: begin
        if (start) begin
          state_nxt = (ld_cls == qlsf_pkg::ST_OK) ? qlsf_pkg::BK_SETUP
                                                   : qlsf_pkg::BK_DONE;
        end
      end
      qlsf_pkg::BK_SETUP: state_nxt = qlsf_pkg::BK_MUL;
      qlsf_pkg::BK_MUL: begin
        if (mul_done) begin
          if (step_r == qlsf_pkg::STEP_W'(qlsf_pkg::DET_STEP)) begin
            state_nxt = qlsf_pkg::BK_CHECK;
          end else if (step_r == qlsf_pkg::STEP_W'(qlsf_pkg::PROG_LEN - 1)) begin
            state_nxt = qlsf_pkg::BK_DIV_SETUP;
          end else begin
            state_nxt = qlsf_pkg::BK_SETUP;
          end
        end
      end
      qlsf_pkg::BK_CHECK: begin
        state_nxt = (det_r == '0) ? qlsf_pkg::BK_DONE : qlsf_pkg::BK_SETUP;
      end
      qlsf_pkg::BK_DIV_SETUP: state_nxt = qlsf_pkg::BK_DIV;
      qlsf_pkg::BK_DIV: begin
        if (div_last) begin
          state_nxt = qlsf_pkg::BK_ROUND;
        end
      end
      qlsf_pkg::BK_ROUND: state_nxt = qlsf_pkg::BK_SAT;
      qlsf_pkg::BK_SAT: begin
        state_nxt = (kidx_r == 2'd2) ? qlsf_pkg::BK_DONE : qlsf_pkg::BK_DIV_SETUP;
      end
      qlsf_pkg::BK_DONE: state_nxt = qlsf_pkg::BK_IDLE;
      default: state_nxt = qlsf_pkg::BK_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    start     = (state_r == qlsf_pkg::BK_IDLE) && !q_empty && !res_v_r;
    q_pop     = start;
    out_empty = ~res_v_r;
  end

  assign out_coef_a     = coef_a_r;
  assign out_coef_b     = coef_b_r;
  assign out_coef_c     = coef_c_r;
  assign out_fit_status = st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= qlsf_pkg::BK_IDLE;
      res_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == qlsf_pkg::BK_DONE) begin
        res_v_r <= 1'b1;
      end else if (out_pop) begin
        res_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      qlsf_pkg::BK_IDLE: begin
        if (start) begin
          s21_r    <= WW'($signed(q_data[O_S11-1:0]));
          s11_r    <= WW'($signed(q_data[O_S01-1:O_S11]));
          s01_r    <= WW'($signed(q_data[O_S40-1:O_S01]));
          s40_r    <= WW'($signed(q_data[O_S30-1:O_S40]));
          s30_r    <= WW'($signed(q_data[O_S20-1:O_S30]));
          s20_r    <= WW'($signed(q_data[O_S10-1:O_S20]));
          s10_r    <= WW'($signed(q_data[O_CNT-1:O_S10]));
          s00_r    <= WW'(q_data[O_CLS-1:O_CNT]);
          st_r     <= ld_cls;
          coef_a_r <= '0;
          coef_b_r <= '0;
          coef_c_r <= '0;
          step_r   <= '0;
          kidx_r   <= '0;
        end
      end
      qlsf_pkg::BK_SETUP: begin
        acc_r <= base_val;
        mc_r  <= opa;
        mp_r  <= opb_abs;
        neg_r <= uop.sub ^ opb[WW-1];
      end
      qlsf_pkg::BK_MUL: begin
        if (mul_done) begin
          case (uop.dst)
            qlsf_pkg::DST_M1:  m1_r  <= acc_r;
            qlsf_pkg::DST_M2:  m2_r  <= acc_r;
            qlsf_pkg::DST_M3:  m3_r  <= acc_r;
            qlsf_pkg::DST_DET: det_r <= acc_r;
            qlsf_pkg::DST_DA:  da_r  <= acc_r;
            qlsf_pkg::DST_DB:  db_r  <= acc_r;
            qlsf_pkg::DST_DC:  dc_r  <= acc_r;
            qlsf_pkg::DST_T:   t_r   <= acc_r;
            default: ;
          endcase
          step_r <= step_r + 1'b1;
        end else begin
          if (mp_r[0]) begin
            acc_r <= neg_r ? acc_r - mc_r : acc_r + mc_r;
          end
          mc_r <= mc_r <<< 1;
          mp_r <= mp_r >> 1;
        end
      end
      qlsf_pkg::BK_CHECK: begin
        if (det_r == '0) begin
          st_r <= qlsf_pkg::ST_SINGULAR;
        end
      end
      qlsf_pkg::BK_DIV_SETUP: begin
        dn_r   <= num_abs << FRAC_BITS;
        dd_r   <= det_abs;
        r_r    <= '0;
        q_r    <= '0;
        dcnt_r <= '0;
        dneg_r <= num_sel[WW-1] ^ det_r[WW-1];
      end
      qlsf_pkg::BK_DIV: begin
        r_r    <= ge ? rs - dd_r : rs;
        q_r    <= {q_r[WW-2:0], ge};
        dn_r   <= dn_r << 1;
        dcnt_r <= dcnt_r + 1'b1;
      end
      qlsf_pkg::BK_ROUND: begin
        q_r <= q_r + WW'(rnd_up);
      end
      qlsf_pkg::BK_SAT: begin
        case (kidx_r)
          2'd0:    coef_a_r <= sat_val;
          2'd1:    coef_b_r <= sat_val;
          default: coef_c_r <= sat_val;
        endcase
        kidx_r <= kidx_r + 1'b1;
      end
      default: ;
    endcase
  end

  a_pop_ok: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (!q_empty && !res_v_r))
    else $error("solver took a snapshot while busy or from an empty queue");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == qlsf_pkg::BK_DIV) |-> (dd_r != '0))
    else $error("division started with a zero determinant");

  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (res_v_r && st_r != qlsf_pkg::ST_OK) |->
      (coef_a_r == '0 && coef_b_r == '0 && coef_c_r == '0))
    else $error("flagged result carries nonzero coefficients");

endmodule

`default_nettype wire

// File: rtl/quadratic_least_squares_fit.sv
// Top level of the quadratic least-squares fit, y = a*x^2 + b*x + c.
// Instantiates qlsf_front, qlsf_queue and qlsf_back; uses qlsf_pkg.
//
// Usage. Sample words (x, y, last flag) enter through a queue-like port:
// a word is taken on a clock edge with in_push high and in_full low. The
// front end has two multiplier stages; it takes no new word while the first
// holds one. Words without the last flag only update the running sums.
// A word with the last flag closes the set: its sums go into a two-entry
// snapshot queue and the sums clear, so the next set can start at once.
// The solver takes one snapshot at a time. Flagged sets (fewer than three
// points, too many points) skip the solve. A full solve runs 30 shift-add
// multiplies, then three restoring divisions with rounding and saturation,
// each over the working width WW (WW = 128 at the default parameters).
// Results appear on the out_ ports while out_empty is low and are taken
// with out_pop. While a result waits, the solver holds it; points keep
// coming in until the snapshot queue fills, then in_full stays high.
// Synchronous reset (rst_n low) clears the sums, the queue and the result.
`default_nettype none

module quadratic_least_squares_fit #(
  parameter int MAX_POINTS   = qlsf_pkg::MAX_POINTS_DEF,
  parameter int SAMPLE_WIDTH = qlsf_pkg::SAMPLE_WIDTH_DEF,
  parameter int FRAC_BITS    = qlsf_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic signed [SAMPLE_WIDTH-1:0]       in_x_value,
  input  wire logic signed [SAMPLE_WIDTH-1:0]       in_y_value,
  input  wire logic                                 in_last_point,
  input  wire logic                                 in_push,
  output logic                                      in_full,
  output logic signed [qlsf_pkg::COEF_W-1:0]        out_coef_a,
  output logic signed [qlsf_pkg::COEF_W-1:0]        out_coef_b,
  output logic signed [qlsf_pkg::COEF_W-1:0]        out_coef_c,
  output logic [1:0]                                out_fit_status,
  output logic                                      out_empty,
  input  wire logic                                 out_pop
);

  // Width of one sum snapshot; matches the packing in the front end.
  localparam int CW  = qlsf_pkg::count_w(MAX_POINTS);
  localparam int PW  = 2 + CW
                     + 2 * qlsf_pkg::sum_w(SAMPLE_WIDTH, CW, 1)
                     + 2 * qlsf_pkg::sum_w(SAMPLE_WIDTH, CW, 2)
                     + 2 * qlsf_pkg::sum_w(SAMPLE_WIDTH, CW, 3)
                     + qlsf_pkg::sum_w(SAMPLE_WIDTH, CW, 4);

  logic          q_push, q_full, q_pop, q_empty;
  logic [PW-1:0] q_wr_data, q_rd_data;

  qlsf_front #(
    .MAX_POINTS   (MAX_POINTS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_x_value    (in_x_value),
    .in_y_value    (in_y_value),
    .in_last_point (in_last_point),
    .in_push       (in_push),
    .in_full       (in_full),
    .q_push        (q_push),
    .q_full        (q_full),
    .q_data        (q_wr_data)
  );

  qlsf_queue #(
    .W (PW)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr_data),
    .full    (q_full),
    .pop     (q_pop),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  qlsf_back #(
    .MAX_POINTS   (MAX_POINTS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .FRAC_BITS    (FRAC_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_data         (q_rd_data),
    .q_pop          (q_pop),
    .out_pop        (out_pop),
    .out_empty      (out_empty),
    .out_coef_a     (out_coef_a),
    .out_coef_b     (out_coef_b),
    .out_coef_c     (out_coef_c),
    .out_fit_status (out_fit_status)
  );

endmodule

`default_nettype wire
